### sv/prgp_pkg.sv
// ---------------------------------------------------------------------------
// prgp_pkg: shared types and constants for the pose range gate
// Word layouts, register indexes, table sizing and the sequencer encodings
// used by the gate and its distance unit.
// ---------------------------------------------------------------------------
package prgp_pkg;

	// Table and arithmetic sizing
	localparam int MAX_POSES     = 256;
	localparam int POSE_IDX_BITS = $clog2(MAX_POSES);
	localparam int COUNT_BITS    = 9;
	localparam int COORD_BITS    = 32;
	localparam int MAG_BITS      = COORD_BITS;
	localparam int SQ_BITS       = 2 * MAG_BITS;
	localparam int ACC_BITS      = SQ_BITS + 2;
	localparam int DIST_BITS     = 62;
	localparam int SEQ_BITS      = 32;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_IDX_BITS  = 1;

	// Function codes of a request word
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TEST = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DIST_SQ = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_POSE_COUNT  = 1'd1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// Request word: load one anchor or test one point
	typedef struct packed {
		logic                     func;
		logic [POSE_IDX_BITS-1:0] pose_slot;
		coord_t                   coord_x;
		coord_t                   coord_y;
		coord_t                   coord_z;
	} req_word_t;

	// Response word: one per tested point
	typedef struct packed {
		logic                in_range;
		logic [SEQ_BITS-1:0] point_number;
	} rsp_word_t;

	// One 3-D position, used for both anchors and the point under test
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} pos_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CALC,
		ST_CHECK,
		ST_FINISH
	} state_t;

	// Steps of one distance evaluation on the shared unit
	typedef enum logic [2:0] {
		CS_DIFF_X,
		CS_DIFF_Y,
		CS_DIFF_Z,
		CS_ADD_Y,
		CS_ADD_Z
	} calc_step_t;

	// Control from the sequencer to the distance unit
	typedef struct packed {
		logic       run;
		calc_step_t step;
	} calc_ctrl_t;

endpackage

### sv/point_range_gate_to_pose_set.sv
// ---------------------------------------------------------------------------
// point_range_gate_to_pose_set: fixed-radius gate against a pose table
// Loads anchor positions into a table and tests points against the first
// pose_count anchors, stopping at the first anchor inside the radius.
// ---------------------------------------------------------------------------
// Usage:
// The request channel (req_valid/req_ready/req_word) carries load words and
// test words. A load word writes one anchor and produces no response.
// A test word produces one response word on the rsp channel with
// the in_range flag and the running point number.
// Configuration writes on the cfg channel are always taken, one per cycle:
// index 0 is the squared radius, index 1 the number of anchors searched.
// Each anchor goes through the shared subtract/multiply/accumulate unit as
// one table read, five steps of the three-axis pipeline and one compare.
// A test word searches up to N anchors, stopping at the first hit, and then
// waits until the output register is free; req_ready is low meanwhile, so a
// new word is taken only once the previous response has been registered.
// The response sits in an output register, so a stalled receiver only holds
// the block once a second response is ready. Reset clears the registers,
// the point counter and the sequencer; the anchor table is not cleared.
// ---------------------------------------------------------------------------
module point_range_gate_to_pose_set
	import prgp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  req_word_t                req_word,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output rsp_word_t                rsp_word
);

	state_t                   state_q;
	state_t                   state_d;
	calc_step_t               step_q;
	calc_step_t               step_d;
	logic [DIST_BITS-1:0]     max_dist_q;
	logic [COUNT_BITS-1:0]    pose_count_q;
	logic [COUNT_BITS-1:0]    cnt_q;
	logic [COUNT_BITS-1:0]    cnt_clip;
	logic [COUNT_BITS-1:0]    idx_q;
	logic [COUNT_BITS-1:0]    idx_next;
	logic [SEQ_BITS-1:0]      seq_q;
	logic                     hit_q;
	logic                     rsp_valid_q;
	rsp_word_t                rsp_q;
	pos_t                     point_q;
	pos_t                     anchor;
	pos_t                     req_pos;
	logic                     req_fire;
	logic                     is_test;
	logic                     mem_wr_en;
	logic                     dist_hit;
	logic                     last_pose;
	logic                     rsp_free;
	calc_ctrl_t               calc_ctrl;

	assign req_fire  = req_valid && req_ready;
	assign is_test   = (req_word.func == FUNC_TEST);
	assign req_pos   = '{x: req_word.coord_x, y: req_word.coord_y, z: req_word.coord_z};
	assign cnt_clip  = (pose_count_q > COUNT_BITS'(MAX_POSES)) ?
		COUNT_BITS'(MAX_POSES) : pose_count_q;
	assign idx_next  = idx_q + COUNT_BITS'(1);
	assign last_pose = (idx_next == cnt_q);
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign mem_wr_en = req_fire && !is_test &&
		(COUNT_BITS'(req_word.pose_slot) < COUNT_BITS'(MAX_POSES));

	// Anchor table
	prgp_anchor_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (req_word.pose_slot),
		.wr_data (req_pos),
		.rd_addr (idx_q[POSE_IDX_BITS-1:0]),
		.rd_data (anchor)
	);

	// Shared distance unit
	prgp_dist_unit u_dist (
		.clk         (clk),
		.ctrl        (calc_ctrl),
		.point       (point_q),
		.anchor      (anchor),
		.max_dist_sq (max_dist_q),
		.hit         (dist_hit)
	);

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q   <= '0;
			pose_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_DIST_SQ: max_dist_q   <= cfg_data[DIST_BITS-1:0];
				REG_POSE_COUNT:  pose_count_q <= cfg_data[COUNT_BITS-1:0];
				default:         max_dist_q   <= max_dist_q;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && is_test) begin
					state_d = (cnt_clip == '0) ? ST_FINISH : ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_CALC;
			ST_CALC: begin
				if (step_q == CS_ADD_Z) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = (dist_hit || last_pose) ? ST_FINISH : ST_FETCH;
			ST_FINISH: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Step sequence through the distance unit
	always_comb begin
		case (step_q)
			CS_DIFF_X: step_d = CS_DIFF_Y;
			CS_DIFF_Y: step_d = CS_DIFF_Z;
			CS_DIFF_Z: step_d = CS_ADD_Y;
			CS_ADD_Y:  step_d = CS_ADD_Z;
			default:   step_d = CS_DIFF_X;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req_ready      = (state_q == ST_IDLE);
		calc_ctrl.run  = (state_q == ST_CALC);
		calc_ctrl.step = step_q;
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= CS_DIFF_X;
			idx_q   <= '0;
			cnt_q   <= '0;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					step_q <= CS_DIFF_X;
					idx_q  <= '0;
					cnt_q  <= cnt_clip;
					hit_q  <= 1'b0;
				end
				ST_CALC: step_q <= step_d;
				ST_CHECK: begin
					step_q <= CS_DIFF_X;
					hit_q  <= dist_hit;
					idx_q  <= idx_next;
				end
				default: step_q <= step_q;
			endcase
		end
	end

	// Point under test
	always_ff @(posedge clk) begin
		if (req_fire && is_test) begin
			point_q <= req_pos;
		end
	end

	// Response register and point counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			seq_q       <= '0;
		end else if (state_q == ST_FINISH && rsp_free) begin
			rsp_valid_q <= 1'b1;
			seq_q       <= seq_q + SEQ_BITS'(1);
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && rsp_free) begin
			rsp_q.in_range     <= hit_q;
			rsp_q.point_number <= seq_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

endmodule

### sv/prgp_anchor_mem.sv
// ---------------------------------------------------------------------------
// prgp_anchor_mem: anchor position table
// Single write port and one registered read port holding the pose positions.
// ---------------------------------------------------------------------------
module prgp_anchor_mem
	import prgp_pkg::*;
(
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [POSE_IDX_BITS-1:0] wr_addr,
	input  pos_t                     wr_data,
	input  logic [POSE_IDX_BITS-1:0] rd_addr,
	output pos_t                     rd_data
);

	pos_t mem_q [MAX_POSES];
	pos_t rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

### sv/prgp_dist_unit.sv
// ---------------------------------------------------------------------------
// prgp_dist_unit: shared squared-distance unit
// One subtractor, one 32x32 multiplier and one accumulator, stepped through
// the three axes of one anchor by the sequencer.
// ---------------------------------------------------------------------------
module prgp_dist_unit
	import prgp_pkg::*;
(
	input  logic                 clk,
	input  calc_ctrl_t           ctrl,
	input  pos_t                 point,
	input  pos_t                 anchor,
	input  logic [DIST_BITS-1:0] max_dist_sq,
	output logic                 hit
);

	coord_t                pt_axis;
	coord_t                an_axis;
	logic [COORD_BITS:0]   diff;
	logic [COORD_BITS:0]   diff_neg;
	logic [MAG_BITS-1:0]   mag_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic [ACC_BITS-1:0]   acc_q;

	// Axis selection for the difference stage
	always_comb begin
		case (ctrl.step)
			CS_DIFF_X: begin
				pt_axis = point.x;
				an_axis = anchor.x;
			end
			CS_DIFF_Y: begin
				pt_axis = point.y;
				an_axis = anchor.y;
			end
			default: begin
				pt_axis = point.z;
				an_axis = anchor.z;
			end
		endcase
	end

	// Exact difference and its magnitude, which always fits the coordinate width
	assign diff     = {pt_axis[COORD_BITS-1], pt_axis} - {an_axis[COORD_BITS-1], an_axis};
	assign diff_neg = -diff;

	// Magnitude, square and accumulate stages overlap across the axes
	always_ff @(posedge clk) begin
		if (ctrl.run) begin
			mag_q <= diff[COORD_BITS] ? diff_neg[MAG_BITS-1:0] : diff[MAG_BITS-1:0];
			sq_q  <= SQ_BITS'(mag_q) * SQ_BITS'(mag_q);
			case (ctrl.step)
				CS_DIFF_X: acc_q <= '0;
				CS_DIFF_Y: acc_q <= acc_q;
				default:   acc_q <= acc_q + ACC_BITS'(sq_q);
			endcase
		end
	end

	// The accumulator cannot wrap, so a plain compare matches a saturating sum
	assign hit = acc_q < ACC_BITS'(max_dist_sq);

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking testbench for point_range_gate_to_pose_set
// Loads anchor positions into the pose table and sends test points. A local
// predictor keeps its own copy of the table, the registers and the point
// counter, and checks every response word in order. Directed tests cover the
// coordinate and radius extremes, and random phases vary idling and stalling.
// ---------------------------------------------------------------------------
module tb;
	import prgp_pkg::*;

	localparam int CLK_PERIOD      = 12;
	localparam int RESET_CYCLES    = 5;
	localparam int SETTLE_CYCLES   = 16;
	localparam int HOLD_OFF_CYCLES = 3000;
	localparam int END_WAIT_CYCLES = 20000;
	localparam int MAX_REPORTS     = 40;
	localparam int CLUSTER_SPAN    = 4096;
	localparam int NEAR_SPAN       = 1024;
	localparam longint TIMEOUT_UNITS = 12_000_000;

	localparam logic [DIST_BITS-1:0] DIST_MAX    = '1;
	localparam logic [DIST_BITS-1:0] NEAR_RADIUS = DIST_BITS'(1 << 22);
	localparam int unsigned COUNT_ALL_ONES = (1 << COUNT_BITS) - 1;
	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
	localparam coord_t COORD_FAR = 32'sh4000_0000;

	// Block ports
	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
	logic                     req_valid = 1'b0;
	logic                     req_ready;
	req_word_t                req_word  = '0;
	logic                     rsp_valid;
	logic                     rsp_ready = 1'b0;
	rsp_word_t                rsp_word;

	// Predictor state: anchor table, registers and point counter
	pos_t                  anchor_tab [MAX_POSES];
	logic [DIST_BITS-1:0]  radius_sq    = '0;
	logic [COUNT_BITS-1:0] search_count = '0;
	logic [SEQ_BITS-1:0]   point_seq    = '0;
	rsp_word_t             expected_verdicts [$];

	// Run statistics and stimulus knobs
	int mismatches     = 0;
	int words_sent     = 0;
	int points_checked = 0;
	int cfg_writes     = 0;
	int blocked_cycles = 0;
	int send_idle_pct  = 0;
	int rsp_stall_pct  = 0;
	int hold_request   = 0;
	int hold_left      = 0;

	point_range_gate_to_pose_set u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#(TIMEOUT_UNITS);
		$display("tb: FAIL");
		$finish;
	end

	function automatic pos_t make_pos(input coord_t x, input coord_t y, input coord_t z);
		make_pos = '{x, y, z};
	endfunction

	// Exact square of one axis difference; the magnitude always fits 32 bits.
	function automatic logic [SQ_BITS-1:0] axis_sq(input coord_t a, input coord_t b);
		logic [COORD_BITS:0]  diff;
		logic [SQ_BITS-1:0]   mag;
		diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		if (diff[COORD_BITS])
			diff = -diff;
		mag = SQ_BITS'(diff[COORD_BITS-1:0]);
		return mag * mag;
	endfunction

	// Search the first anchors in order and stop at the first one inside the
	// radius. The sum is kept two bits wider than a square, so it never wraps
	// and the compare against the 62-bit radius is exact.
	function automatic logic predict_hit(input pos_t pt);
		logic [ACC_BITS-1:0] sum_sq;
		int                  n;
		n = (int'(search_count) > MAX_POSES) ? MAX_POSES : int'(search_count);
		for (int i = 0; i < n; i++) begin
			sum_sq = ACC_BITS'(axis_sq(pt.x, anchor_tab[i].x))
				+ ACC_BITS'(axis_sq(pt.y, anchor_tab[i].y))
				+ ACC_BITS'(axis_sq(pt.z, anchor_tab[i].z));
			if (sum_sq < ACC_BITS'(radius_sq))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("tb: mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// A load word updates the table copy; a test word queues its verdict.
	// The slot field is 8 bits wide, so every load lands inside the table.
	task automatic record_word(input req_word_t w);
		rsp_word_t verdict;
		words_sent++;
		if (w.func == FUNC_LOAD) begin
			anchor_tab[w.pose_slot] = make_pos(w.coord_x, w.coord_y, w.coord_z);
		end else begin
			verdict.in_range     = predict_hit(make_pos(w.coord_x, w.coord_y, w.coord_z));
			verdict.point_number = point_seq;
			expected_verdicts    = {expected_verdicts, verdict};
			point_seq++;
		end
	endtask

	task automatic check_verdict(input rsp_word_t got);
		rsp_word_t want;
		if (expected_verdicts.size() == 0) begin
			report_mismatch($sformatf("response for point %0d with nothing pending",
				got.point_number));
			return;
		end
		want = expected_verdicts.pop_front();
		points_checked++;
		if (got.in_range !== want.in_range)
			report_mismatch($sformatf("point %0d: in_range %b, expected %b",
				want.point_number, got.in_range, want.in_range));
		if (got.point_number !== want.point_number)
			report_mismatch($sformatf("point_number %0d, expected %0d",
				got.point_number, want.point_number));
	endtask

	// Watch all three channels and keep the predictor in step with the block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				if (cfg_index == REG_MAX_DIST_SQ)
					radius_sq = cfg_data[DIST_BITS-1:0];
				else if (cfg_index == REG_POSE_COUNT)
					search_count = cfg_data[COUNT_BITS-1:0];
			end
			if (rsp_valid && rsp_ready)
				check_verdict(rsp_word);
			if (req_valid && req_ready)
				record_word(req_word);
			if (req_valid && !req_ready && rsp_valid && !rsp_ready)
				blocked_cycles++;
		end
	end

	// Response side: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// Offer one request word after a random gap. Valid stays high after the
	// word is taken; the caller either sends again or lowers it.
	task automatic send_word(input logic func, input logic [POSE_IDX_BITS-1:0] slot,
		input pos_t p);
		req_word_t w;
		w.func      = func;
		w.pose_slot = slot;
		w.coord_x   = p.x;
		w.coord_y   = p.y;
		w.coord_z   = p.z;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_verdicts.size() != 0);
	endtask

	// A load word may still be in flight after the last response, so wait a
	// little longer before touching the registers.
	task automatic settle();
		drain_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write both registers while idle; unused upper data bits carry noise.
	task automatic set_config(input logic [DIST_BITS-1:0] radius, input int unsigned count);
		logic [CFG_DATA_BITS-1:0] raw;
		settle();
		raw                  = {$urandom, $urandom};
		raw[DIST_BITS-1:0]   = radius;
		write_reg(REG_MAX_DIST_SQ, raw);
		raw                  = {$urandom, $urandom};
		raw[COUNT_BITS-1:0]  = count[COUNT_BITS-1:0];
		write_reg(REG_POSE_COUNT, raw);
		cfg_valid <= 1'b0;
	endtask

	function automatic coord_t spread_coord(input int unsigned span);
		return coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
	endfunction

	function automatic pos_t cluster_pos();
		return make_pos(spread_coord(CLUSTER_SPAN), spread_coord(CLUSTER_SPAN),
			spread_coord(CLUSTER_SPAN));
	endfunction

	function automatic pos_t random_pos();
		return make_pos(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
	endfunction

	function automatic pos_t near_pos(input pos_t a);
		a.x = a.x + spread_coord(NEAR_SPAN);
		a.y = a.y + spread_coord(NEAR_SPAN);
		a.z = a.z + spread_coord(NEAR_SPAN);
		return a;
	endfunction

	// Reset settings search no anchors, so every point misses; loads between
	// tests must not move the point counter.
	task automatic test_empty_search();
		send_word(FUNC_TEST, 8'h00, make_pos(COORD_MAX, COORD_MAX, COORD_MAX));
		send_word(FUNC_LOAD, 8'h00, make_pos(COORD_MAX, COORD_MAX, COORD_MAX));
		send_word(FUNC_LOAD, 8'h01, make_pos(COORD_MIN, COORD_MIN, COORD_MIN));
		send_word(FUNC_TEST, 8'hFF, make_pos(COORD_MIN, COORD_MIN, COORD_MIN));
		set_config(DIST_MAX, 0);
		send_word(FUNC_TEST, 8'h5A, make_pos(COORD_MAX, COORD_MAX, COORD_MAX));
	endtask

	// Opposite corners of the coordinate range, largest and zero radius.
	task automatic test_extremes();
		set_config(DIST_MAX, 1);
		send_word(FUNC_TEST, 8'h00, make_pos(COORD_MIN, COORD_MIN, COORD_MIN));
		send_word(FUNC_TEST, 8'h00, make_pos(COORD_MAX, COORD_MAX, COORD_MAX));
		send_word(FUNC_TEST, 8'h00, make_pos(COORD_MIN, COORD_MAX, COORD_MAX));
		set_config('0, 2);
		send_word(FUNC_TEST, 8'h00, make_pos(COORD_MAX, COORD_MAX, COORD_MAX));
		send_word(FUNC_TEST, 8'h00, make_pos(COORD_MIN, COORD_MIN, COORD_MIN));
		set_config(DIST_MAX, 2);
		send_word(FUNC_TEST, 8'h00, make_pos(COORD_MIN, COORD_MIN, COORD_MIN));
	endtask

	// A distance equal to the radius is outside; one more unit of radius hits.
	task automatic test_radius_edge();
		send_word(FUNC_LOAD, 8'h00, make_pos(256, -512, 0));
		set_config(25, 1);
		send_word(FUNC_TEST, 8'h00, make_pos(259, -508, 0));
		set_config(26, 1);
		send_word(FUNC_TEST, 8'h00, make_pos(259, -508, 0));
		send_word(FUNC_TEST, 8'h00, make_pos(256, -512, 0));
	endtask

	// Only the second anchor is close, so the count decides the verdict.
	task automatic test_first_match();
		send_word(FUNC_LOAD, 8'h01, make_pos(4000, 4000, -4000));
		set_config(100, 2);
		send_word(FUNC_TEST, 8'h00, make_pos(4003, 4000, -4000));
		set_config(100, 1);
		send_word(FUNC_TEST, 8'h00, make_pos(4003, 4000, -4000));
	endtask

	// Fill the whole table, then search all of it, including a count above
	// the table size, which must clamp to the table.
	task automatic test_full_table();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		for (int s = 0; s < MAX_POSES - 1; s++)
			send_word(FUNC_LOAD, POSE_IDX_BITS'(s),
				($urandom_range(9) == 0) ? random_pos() : cluster_pos());
		send_word(FUNC_LOAD, POSE_IDX_BITS'(MAX_POSES - 1),
			make_pos(COORD_FAR, COORD_FAR, COORD_FAR));
		set_config(NEAR_RADIUS, MAX_POSES);
		send_word(FUNC_TEST, 8'h00, near_pos(make_pos(COORD_FAR, COORD_FAR, COORD_FAR)));
		send_word(FUNC_TEST, 8'h00, random_pos());
		send_word(FUNC_TEST, 8'h00, make_pos(COORD_FAR, COORD_FAR, COORD_FAR));
		set_config(NEAR_RADIUS, COUNT_ALL_ONES);
		send_word(FUNC_TEST, 8'h00, make_pos(COORD_FAR, COORD_FAR, COORD_FAR));
		send_word(FUNC_TEST, 8'h00, random_pos());
	endtask

	// Hold the response side off long enough for the block to fill up and
	// drop req_ready while the sender keeps offering words.
	task automatic test_backpressure();
		set_config(NEAR_RADIUS, 4);
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_request  = HOLD_OFF_CYCLES;
		repeat (12)
			send_word(FUNC_TEST, POSE_IDX_BITS'($urandom),
				near_pos(anchor_tab[$urandom_range(0, 3)]));
		drain_responses();
	endtask

	// Random traffic under one idling and stalling setting, in three register settings.
	// Most points sit near a searched anchor so that both verdicts show up.
	task automatic run_random_phase(input int idle_pct, input int stall_pct,
		input int n_words);
		logic [DIST_BITS-1:0]     radius;
		int unsigned              count;
		int unsigned              pick;
		logic [POSE_IDX_BITS-1:0] slot;
		pos_t                     pt;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		for (int blk = 0; blk < 3; blk++) begin
			pick = $urandom_range(99);
			if (pick < 5)
				radius = '0;
			else if (pick < 10)
				radius = DIST_MAX;
			else if (pick < 20)
				radius = DIST_BITS'({$urandom, $urandom});
			else
				radius = DIST_BITS'($urandom_range(1 << 16, 1 << 22));
			pick = $urandom_range(99);
			if (pick < 8)
				count = 0;
			else if (pick < 20)
				count = $urandom_range(13, 40);
			else
				count = $urandom_range(1, 12);
			set_config(radius, count);
			repeat (n_words / 3) begin
				if ($urandom_range(99) < 25) begin
					slot = POSE_IDX_BITS'($urandom_range(0, count + 3));
					send_word(FUNC_LOAD, slot,
						($urandom_range(4) == 0) ? random_pos() : cluster_pos());
				end else begin
					pick = $urandom_range(99);
					if (pick < 70 && count != 0)
						pt = near_pos(anchor_tab[$urandom_range(0, count - 1)]);
					else if (pick < 90)
						pt = cluster_pos();
					else
						pt = random_pos();
					send_word(FUNC_TEST, POSE_IDX_BITS'($urandom), pt);
				end
				// Now and then the sender waits for every response.
				if ($urandom_range(99) < 2)
					drain_responses();
			end
		end
	endtask

	initial begin
		int wait_left;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_search();
		test_extremes();
		test_radius_edge();
		test_first_match();
		test_full_table();
		test_backpressure();
		run_random_phase(0, 0, 111);
		run_random_phase(88, 0, 111);
		run_random_phase(0, 88, 111);
		run_random_phase(15, 15, 111);

		// Wait for the last responses, with a limit, then let the block go quiet.
		req_valid <= 1'b0;
		wait_left = END_WAIT_CYCLES;
		do begin
			@(posedge clk);
			wait_left--;
		end while (expected_verdicts.size() != 0 && wait_left > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_verdicts.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived",
				expected_verdicts.size()));

		$display("tb: %0d words accepted, %0d responses checked, %0d register writes",
			words_sent, points_checked, cfg_writes);
		$display("tb: input blocked by a full output for %0d cycles, %0d mismatches",
			blocked_cycles, mismatches);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
